// File: hdl/fixed_point_alu_with_arctan_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point ALU
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_WITH_ARCTAN_ASSERT_SVH
`define FIXED_POINT_ALU_WITH_ARCTAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FPALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fixed_point_alu_with_arctan: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define FPALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fixed_point_alu_with_arctan: next-cycle check failed");

`endif

// File: hdl/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Word sizes, default fraction width and operation codes.
// ----------------------------------------------------------------------------
package fpalu_pkg;

    localparam int WORD_W        = 32;
    localparam int MODE_W        = 3;
    localparam int FRAC_BITS_DEF = 12;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_SQR  = 3'd4,
        MODE_ATAN = 3'd5
    } t_mode;

endpackage

// File: hdl/fpalu_in_if.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU request channel
// Valid/ready channel carrying the operation code and both operands.
// ----------------------------------------------------------------------------
interface fpalu_in_if
    import fpalu_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;

    modport source (output valid, output mode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input mode, input operand_a, input operand_b,
                    output ready);
endinterface

// File: hdl/fpalu_out_if.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU result channel
// Valid/ready channel carrying the result word and the zero-divisor flag.
// ----------------------------------------------------------------------------
interface fpalu_out_if
    import fpalu_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] result;
    logic                     divide_by_zero;

    modport source (output valid, output result, output divide_by_zero, input ready);
    modport sink   (input valid, input result, input divide_by_zero, output ready);
endinterface

// File: hdl/fixed_point_alu_with_arctan.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU with arctangent
// Pipelined signed fixed-point add, subtract, multiply, divide, square and
// Pade arctangent with a bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_req (mode, operand_a, operand_b) and results
// leave on o_rsp (result, divide_by_zero), both valid/ready channels.
// Every request gives exactly one result, in request order.
// Every mode, from acceptance to o_rsp.valid, passes through the 32 + FRAC_BITS
// stages of the restoring divider, one quotient bit per stage, behind the
// stages of operand capture, multiply, rounding, divide setup and magnitudes.
// Throughput is one request per clock while the receiver keeps up.
// The output register is backed by a one-entry skid register; the whole
// pipeline advances together and halts only while the skid register is
// occupied, so a stalled receiver loses or repeats nothing and a new
// request is still taken while one result waits.
// A zero divisor, also the internal one of arctan, saturates the result
// toward the numerator's sign and raises divide_by_zero.
// Reset (synchronous, active low) clears every valid bit, output and skid
// flags included; the block is ready in the cycle after reset is released.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_with_arctan_assert.svh"

module fixed_point_alu_with_arctan
    import fpalu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fpalu_in_if.sink     i_req,
    fpalu_out_if.source  o_rsp
);

    localparam int DW  = WORD_W + FRAC_BITS;      // dividend magnitude bits
    localparam int TW  = WORD_W + FRAC_BITS + 2;  // signed shifted numerator
    localparam int PW  = 2 * WORD_W;              // product width
    localparam int NST = 5 + DW;                  // pipeline stages with valid bits

    localparam logic [PW-1:0]            C3_WIDE = 64'd3 << FRAC_BITS;
    localparam logic signed [WORD_W-1:0] C3      = C3_WIDE[WORD_W-1:0];
    localparam logic signed [PW-1:0]     RND     = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic [WORD_W-1:0]        SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0]        SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [DW-1:0]     work;
        logic [WORD_W-1:0] dmag;
        logic              neg;
        logic              is_div;
        logic              zero;
        logic [WORD_W-1:0] alt;
    } t_dstage;

    // One restoring step: bring in the next dividend bit, shift in a quotient bit.
    function automatic t_dstage f_div_step(input t_dstage s);
        t_dstage           o;
        logic [WORD_W:0]   rem_sh;
        logic [WORD_W:0]   diff;
        logic              ge;
        o      = s;
        rem_sh = {s.rem, s.work[DW-1]};
        diff   = rem_sh - {1'b0, s.dmag};
        ge     = (rem_sh >= {1'b0, s.dmag});
        o.rem  = ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
        o.work = {s.work[DW-2:0], ge};
        return o;
    endfunction

    logic [NST-1:0] r_vld;
    logic           w_en;
    logic           w_push;

    // Stage 0: operand capture.
    logic [MODE_W-1:0]        r0_mode;
    logic signed [WORD_W-1:0] r0_a, r0_b;
    // Stage 1: raw products.
    logic [MODE_W-1:0]        r1_mode;
    logic signed [WORD_W-1:0] r1_a, r1_b;
    logic signed [PW-1:0]     r1_p1, r1_p2;
    // Stage 2: rounded products.
    logic [MODE_W-1:0]        r2_mode;
    logic signed [WORD_W-1:0] r2_a, r2_b, r2_mul, r2_den;
    // Stage 3: shifted and biased numerator.
    logic signed [TW-1:0]     r3_t;
    logic signed [WORD_W-1:0] r3_d;
    logic                     r3_div, r3_zero;
    logic [WORD_W-1:0]        r3_alt;
    // Stage 4 onward: divider.
    t_dstage                  r_ds [DW+1];

    // Output register and skid register.
    logic                     r_out_v, r_skid_v;
    logic [WORD_W-1:0]        r_out_res, r_skid_res;
    logic                     r_out_dz, r_skid_dz;

    assign w_en        = !r_skid_v;
    assign i_req.ready = w_en;

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_req.valid};
        end
    end

    // ---------------- stage 0 ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_mode <= i_req.mode;
            r0_a    <= i_req.operand_a;
            r0_b    <= i_req.operand_b;
        end
    end

    // ---------------- stage 1: multipliers ----------------
    logic signed [WORD_W-1:0] w1_ma, w1_mb;

    always_comb begin
        w1_ma = r0_a;
        w1_mb = r0_b;
        case (r0_mode)
            MODE_SQR:  w1_mb = r0_a;
            MODE_ATAN: begin
                w1_ma = C3;
                w1_mb = r0_a;
            end
            default:   w1_mb = r0_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mode <= r0_mode;
            r1_a    <= r0_a;
            r1_b    <= r0_b;
            r1_p1   <= PW'(w1_ma) * PW'(w1_mb);
            r1_p2   <= PW'(r0_a) * PW'(r0_a);
        end
    end

    // ---------------- stage 2: rounding ----------------
    logic signed [PW-1:0]     w2_s1, w2_s2;
    logic signed [WORD_W-1:0] w2_sq;

    always_comb begin
        w2_s1 = r1_p1 + RND;
        w2_s2 = r1_p2 + RND;
        w2_sq = w2_s2[FRAC_BITS+WORD_W-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mode <= r1_mode;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_mul  <= w2_s1[FRAC_BITS+WORD_W-1:FRAC_BITS];
            r2_den  <= w2_sq + C3;
        end
    end

    // ---------------- stage 3: divide setup ----------------
    logic signed [WORD_W-1:0] w3_n, w3_d, w3_hd;
    logic signed [TW-1:0]     w3_t, w3_hd_ext, w3_tadj;
    logic                     w3_isdiv, w3_zero;
    logic [WORD_W-1:0]        w3_alt;

    always_comb begin
        w3_isdiv = (r2_mode == MODE_DIV) || (r2_mode == MODE_ATAN);
        w3_n     = (r2_mode == MODE_ATAN) ? r2_mul : r2_a;
        w3_d     = (r2_mode == MODE_ATAN) ? r2_den : r2_b;
        w3_zero  = w3_isdiv && (w3_d == '0);
        case (r2_mode)
            MODE_ADD: w3_alt = r2_a + r2_b;
            MODE_SUB: w3_alt = r2_a - r2_b;
            MODE_MUL: w3_alt = r2_mul;
            MODE_SQR: w3_alt = r2_mul;
            default:  w3_alt = '0;
        endcase
        if (w3_zero) begin
            w3_alt = w3_n[WORD_W-1] ? SAT_NEG : SAT_POS;
        end
        // Half the divisor, rounded toward zero.
        w3_hd     = $signed(w3_d + WORD_W'(w3_d[WORD_W-1])) >>> 1;
        w3_hd_ext = TW'(w3_hd);
        w3_t      = TW'(w3_n) <<< FRAC_BITS;
        w3_tadj   = (w3_t[TW-1] == w3_d[WORD_W-1]) ? (w3_t + w3_hd_ext)
                                                  : (w3_t - w3_hd_ext);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_t    <= w3_tadj;
            r3_d    <= w3_d;
            r3_div  <= w3_isdiv && !w3_zero;
            r3_zero <= w3_zero;
            r3_alt  <= w3_alt;
        end
    end

    // ---------------- stage 4: magnitudes ----------------
    logic signed [TW-1:0] w4_tabs;
    t_dstage              w4_ds;

    always_comb begin
        w4_tabs       = r3_t[TW-1] ? -r3_t : r3_t;
        w4_ds.rem     = '0;
        w4_ds.work    = w4_tabs[DW-1:0];
        w4_ds.dmag    = r3_d[WORD_W-1] ? WORD_W'(-r3_d) : WORD_W'(r3_d);
        w4_ds.neg     = r3_t[TW-1] ^ r3_d[WORD_W-1];
        w4_ds.is_div  = r3_div;
        w4_ds.zero    = r3_zero;
        w4_ds.alt     = r3_alt;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ds[0] <= w4_ds;
        end
    end

    // ---------------- divider stages ----------------
    for (genvar k = 0; k < DW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ds[k+1] <= f_div_step(r_ds[k]);
            end
        end
    end

    // ---------------- final select ----------------
    logic [WORD_W-1:0] w_fin_q, w_fin_res;

    always_comb begin
        w_fin_q   = r_ds[DW].work[WORD_W-1:0];
        w_fin_res = r_ds[DW].is_div ? (r_ds[DW].neg ? -w_fin_q : w_fin_q)
                                    : r_ds[DW].alt;
    end

    assign w_push = w_en && r_vld[NST-1];

    // ---------------- output and skid registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_rsp.ready) begin
                r_out_res <= r_skid_res;
                r_out_dz  <= r_skid_dz;
                r_skid_v  <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_v || o_rsp.ready) begin
                r_out_v   <= 1'b1;
                r_out_res <= w_fin_res;
                r_out_dz  <= r_ds[DW].zero;
            end else begin
                r_skid_v   <= 1'b1;
                r_skid_res <= w_fin_res;
                r_skid_dz  <= r_ds[DW].zero;
            end
        end else if (o_rsp.ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_rsp.valid          = r_out_v;
    assign o_rsp.result         = r_out_res;
    assign o_rsp.divide_by_zero = r_out_dz;

    // ---------------- assertions ----------------
    `FPALU_ASSERT_IMP(a_skid_implies_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `FPALU_ASSERT_IMP(a_dz_saturates, i_clk, i_rst_n, r_out_v && r_out_dz,
        (r_out_res == SAT_POS) || (r_out_res == SAT_NEG))
    `FPALU_ASSERT_NXT(a_stall_freezes, i_clk, i_rst_n, !w_en, $stable(r_vld))

endmodule
